/* hw/rtl/csot_pkg.sv */
// Shared types, widths and codes for the convex shape overlap test core.
package csot_pkg;

    // Field and datapath widths
    localparam int FIELD_W = 24;               // stored coordinate width
    localparam int VERT_W  = 2 * FIELD_W;      // one stored vertex: y above x
    localparam int RAD_W   = 23;
    localparam int AXIS_W  = FIELD_W + 1;      // difference of two coordinates
    localparam int MUL_W   = FIELD_W + 2;      // shared multiplier operand
    localparam int PROD_W  = 2 * MUL_W;        // shared multiplier product
    localparam int ACC_W   = PROD_W + 2;       // projections and sums
    localparam int ROOT_W  = FIELD_W + 1;      // square root of an axis length
    localparam int SQ_IN_W = 2 * ROOT_W;

    // Shape kinds
    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_POLY   = 2'd1;
    localparam logic [1:0] KIND_CIRCLE = 2'd2;

    // Axis passes; the last code means no pass remains
    localparam logic [2:0] PASS_A_EDGE   = 3'd0;
    localparam logic [2:0] PASS_B_EDGE   = 3'd1;
    localparam logic [2:0] PASS_A_CENTER = 3'd2;
    localparam logic [2:0] PASS_B_CENTER = 3'd3;
    localparam logic [2:0] PASS_NONE     = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIST_RD,
        S_DIST_X,
        S_DIST_MX,
        S_DIST_MY,
        S_DIST_MR,
        S_DIST_CMP,
        S_AX_RD_I,
        S_AX_RD_J,
        S_AX_CALC,
        S_LEN_X,
        S_LEN_Y,
        S_LEN_SUM,
        S_LEN_ROOT,
        S_PR_RD,
        S_PR_X,
        S_PR_Y,
        S_PR_ACC,
        S_PR_EXT,
        S_PR_EXT2,
        S_PR_END,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [RAD_W-1:0] radius;
    } shape_info_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic collide;
    } seq_status_t;

    // Unused kind codes and polygons with fewer than two vertices act as points
    function automatic logic [1:0] eff_kind(input logic [1:0] kind, input logic few);
        logic [1:0] k;
        k = kind;
        if (kind != KIND_POINT && kind != KIND_POLY && kind != KIND_CIRCLE) begin
            k = KIND_POINT;
        end
        if (kind == KIND_POLY && few) begin
            k = KIND_POINT;
        end
        return k;
    endfunction

    function automatic logic pass_used(input logic [2:0] p, input logic [1:0] ka,
                                       input logic [1:0] kb);
        logic u;
        u = 1'b0;
        if (p == PASS_A_EDGE)   u = (ka == KIND_POLY);
        if (p == PASS_B_EDGE)   u = (kb == KIND_POLY);
        if (p == PASS_A_CENTER) u = (ka == KIND_CIRCLE);
        if (p == PASS_B_CENTER) u = (kb == KIND_CIRCLE);
        return u;
    endfunction

    // First used pass at or after a given one
    function automatic logic [2:0] find_pass(input logic [2:0] from, input logic [1:0] ka,
                                             input logic [1:0] kb);
        logic [2:0] r;
        r = PASS_NONE;
        for (int p = 3; p >= 0; p--) begin
            if (3'(p) >= from && pass_used(3'(p), ka, kb)) begin
                r = 3'(p);
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/csot_vmem.sv */
// Vertex store: one write port, one registered read port.
module csot_vmem #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [csot_pkg::VERT_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [csot_pkg::VERT_W-1:0] rd_data
);
    import csot_pkg::*;

    logic [VERT_W-1:0] mem [DEPTH];
    logic [VERT_W-1:0] rd_data_reg;

    // Write when enabled, read every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/csot_isqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
module csot_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [csot_pkg::SQ_IN_W-1:0] operand,
    output logic                        root_valid,
    output logic [csot_pkg::ROOT_W-1:0] root
);
    import csot_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CW    = $clog2(ROOT_W);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [SQ_IN_W-1:0] src_reg, src_next;
    logic [ROOT_W:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;

    // One restoring step per cycle
    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rem_sh    = {rem_reg, src_reg[SQ_IN_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start) begin
            run_next  = 1'b1;
            cnt_next  = '0;
            src_next  = operand;
            rem_next  = '0;
            root_next = '0;
        end else if (run_reg) begin
            src_next = src_reg << 2;
            if (rem_sh >= trial) begin
                rem_next  = (ROOT_W + 1)'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = (ROOT_W + 1)'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(ROOT_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root_valid = done_reg;
    assign root       = root_reg;

endmodule

/* hw/rtl/csot_seq.sv */
// Test sequencer: axis walk, projections and distance check on one shared multiplier.
module csot_seq #(
    parameter int MAX_VERTICES = 16,
    localparam int CNT_W = $clog2(MAX_VERTICES + 1),
    localparam int IDX_W = $clog2(MAX_VERTICES)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [CNT_W-1:0]             n_a,
    input  logic [CNT_W-1:0]             n_b,
    input  csot_pkg::shape_info_t        info_a,
    input  csot_pkg::shape_info_t        info_b,
    output logic [IDX_W-1:0]             addr_a,
    output logic [IDX_W-1:0]             addr_b,
    input  logic [csot_pkg::VERT_W-1:0]  rdata_a,
    input  logic [csot_pkg::VERT_W-1:0]  rdata_b,
    input  logic                         ack,
    output csot_pkg::seq_status_t        status
);
    import csot_pkg::*;

    seq_state_t state_reg, state_next;

    logic [CNT_W-1:0]         na_reg, na_next, nb_reg, nb_next;
    logic [1:0]               ka_reg, ka_next, kb_reg, kb_next;
    logic [RAD_W-1:0]         ra_reg, ra_next, rb_reg, rb_next;
    logic [2:0]               pass_reg, pass_next;
    logic [IDX_W-1:0]         i_reg, i_next, k_reg, k_next;
    logic                     shp_reg, shp_next;
    logic                     coll_reg, coll_next;
    logic signed [FIELD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [FIELD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [FIELD_W-1:0] vy_reg, vy_next;
    logic signed [AXIS_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [ROOT_W-1:0]        len_reg, len_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  min_reg, min_next, max_reg, max_next;
    logic signed [ACC_W-1:0]  amin_reg, amin_next, amax_reg, amax_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MUL_W-1:0]  mul_a, mul_b;

    logic                     sq_start, sq_valid;
    logic [SQ_IN_W-1:0]       sq_in;
    logic [ROOT_W-1:0]        sq_root;

    logic                     own_b, edge_pass;
    logic [CNT_W-1:0]         n_own, n_shp;
    logic [1:0]               k_shp, ka_e, kb_e;
    logic [RAD_W-1:0]         r_shp;
    logic [VERT_W-1:0]        own_d, oth_d, shp_d;
    logic signed [ACC_W-1:0]  prod_x, dot;
    logic [CNT_W-1:0]         i_inc, k_inc;
    logic [2:0]               pass_after;

    csot_isqrt u_isqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (sq_start),
        .operand    (sq_in),
        .root_valid (sq_valid),
        .root       (sq_root)
    );

    // Shared multiplier, registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Selection helpers
    always_comb begin
        own_b      = (pass_reg == PASS_B_EDGE) || (pass_reg == PASS_A_CENTER);
        edge_pass  = (pass_reg == PASS_A_EDGE) || (pass_reg == PASS_B_EDGE);
        n_own      = own_b ? nb_reg : na_reg;
        own_d      = own_b ? rdata_b : rdata_a;
        oth_d      = own_b ? rdata_a : rdata_b;
        n_shp      = shp_reg ? nb_reg : na_reg;
        k_shp      = shp_reg ? kb_reg : ka_reg;
        r_shp      = shp_reg ? rb_reg : ra_reg;
        shp_d      = shp_reg ? rdata_b : rdata_a;
        prod_x     = ACC_W'(prod_reg);
        dot        = acc_reg + prod_x;
        i_inc      = CNT_W'(i_reg) + CNT_W'(1);
        k_inc      = CNT_W'(k_reg) + CNT_W'(1);
        pass_after = find_pass(pass_reg + 3'd1, ka_reg, kb_reg);
        ka_e       = eff_kind(info_a.kind, n_a < CNT_W'(2));
        kb_e       = eff_kind(info_b.kind, n_b < CNT_W'(2));
    end

    // Next state and datapath control
    always_comb begin
        state_next = state_reg;
        na_next = na_reg;     nb_next = nb_reg;
        ka_next = ka_reg;     kb_next = kb_reg;
        ra_next = ra_reg;     rb_next = rb_reg;
        pass_next = pass_reg; i_next = i_reg; k_next = k_reg;
        shp_next = shp_reg;   coll_next = coll_reg;
        px_next = px_reg;     py_next = py_reg;
        cx_next = cx_reg;     cy_next = cy_reg;
        vy_next = vy_reg;
        ax_next = ax_reg;     ay_next = ay_reg;
        len_next = len_reg;   acc_next = acc_reg;
        min_next = min_reg;   max_next = max_reg;
        amin_next = amin_reg; amax_next = amax_reg;
        addr_a = '0;
        addr_b = '0;
        mul_a = '0;
        mul_b = '0;
        sq_start = 1'b0;
        sq_in = SQ_IN_W'(dot);
        status.idle = 1'b0;
        status.done = 1'b0;
        status.collide = coll_reg;

        unique case (state_reg)
            S_IDLE: begin
                status.idle = 1'b1;
                if (start) begin
                    na_next = n_a;  nb_next = n_b;
                    ka_next = ka_e; kb_next = kb_e;
                    ra_next = info_a.radius;
                    rb_next = info_b.radius;
                    i_next  = '0;
                    pass_next = find_pass(PASS_A_EDGE, ka_e, kb_e);
                    if (n_a == '0 || n_b == '0) begin
                        coll_next  = 1'b0;
                        state_next = S_DONE;
                    end else if (ka_e != KIND_POLY && kb_e != KIND_POLY) begin
                        state_next = S_DIST_RD;
                    end else begin
                        state_next = S_AX_RD_I;
                    end
                end
            end

            // Point and circle pairs: squared distance against squared radius sum
            S_DIST_RD: state_next = S_DIST_X;
            S_DIST_X: begin
                ax_next = AXIS_W'($signed(rdata_b[FIELD_W-1:0]))
                        - AXIS_W'($signed(rdata_a[FIELD_W-1:0]));
                ay_next = AXIS_W'($signed(rdata_b[VERT_W-1:FIELD_W]))
                        - AXIS_W'($signed(rdata_a[VERT_W-1:FIELD_W]));
                state_next = S_DIST_MX;
            end
            S_DIST_MX: begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(ax_reg);
                state_next = S_DIST_MY;
            end
            S_DIST_MY: begin
                mul_a = MUL_W'(ay_reg);
                mul_b = MUL_W'(ay_reg);
                acc_next = prod_x;
                state_next = S_DIST_MR;
            end
            S_DIST_MR: begin
                mul_a = $signed(MUL_W'((ka_reg == KIND_CIRCLE) ? ra_reg : '0)
                              + MUL_W'((kb_reg == KIND_CIRCLE) ? rb_reg : '0));
                mul_b = mul_a;
                acc_next = dot;
                state_next = S_DIST_CMP;
            end
            S_DIST_CMP: begin
                coll_next  = (acc_reg <= prod_x);
                state_next = S_DONE;
            end

            // Fetch the vertices that define the current axis
            S_AX_RD_I: begin
                if (own_b) begin
                    addr_b = i_reg;
                end else begin
                    addr_a = i_reg;
                end
                state_next = S_AX_RD_J;
            end
            S_AX_RD_J: begin
                px_next = $signed(own_d[FIELD_W-1:0]);
                py_next = $signed(own_d[VERT_W-1:FIELD_W]);
                cx_next = $signed(oth_d[FIELD_W-1:0]);
                cy_next = $signed(oth_d[VERT_W-1:FIELD_W]);
                if (own_b) begin
                    addr_b = (i_inc == n_own) ? '0 : IDX_W'(i_inc);
                end else begin
                    addr_a = (i_inc == n_own) ? '0 : IDX_W'(i_inc);
                end
                state_next = S_AX_CALC;
            end
            S_AX_CALC: begin
                if (edge_pass) begin
                    ax_next = AXIS_W'(py_reg) - AXIS_W'($signed(own_d[VERT_W-1:FIELD_W]));
                    ay_next = AXIS_W'($signed(own_d[FIELD_W-1:0])) - AXIS_W'(px_reg);
                end else begin
                    ax_next = AXIS_W'(px_reg) - AXIS_W'(cx_reg);
                    ay_next = AXIS_W'(py_reg) - AXIS_W'(cy_reg);
                end
                shp_next = 1'b0;
                k_next   = '0;
                if (ka_reg == KIND_CIRCLE || kb_reg == KIND_CIRCLE) begin
                    state_next = S_LEN_X;
                end else begin
                    state_next = S_PR_RD;
                end
            end

            // Axis length for circle half-extents
            S_LEN_X: begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(ax_reg);
                state_next = S_LEN_Y;
            end
            S_LEN_Y: begin
                mul_a = MUL_W'(ay_reg);
                mul_b = MUL_W'(ay_reg);
                acc_next = prod_x;
                state_next = S_LEN_SUM;
            end
            S_LEN_SUM: begin
                sq_start = 1'b1;
                state_next = S_LEN_ROOT;
            end
            S_LEN_ROOT: begin
                if (sq_valid) begin
                    len_next   = sq_root;
                    state_next = S_PR_RD;
                end
            end

            // Project one vertex of the current shape
            S_PR_RD: begin
                if (shp_reg) begin
                    addr_b = k_reg;
                end else begin
                    addr_a = k_reg;
                end
                state_next = S_PR_X;
            end
            S_PR_X: begin
                mul_a = MUL_W'($signed(shp_d[FIELD_W-1:0]));
                mul_b = MUL_W'(ax_reg);
                vy_next = $signed(shp_d[VERT_W-1:FIELD_W]);
                state_next = S_PR_Y;
            end
            S_PR_Y: begin
                mul_a = MUL_W'(vy_reg);
                mul_b = MUL_W'(ay_reg);
                acc_next = prod_x;
                state_next = S_PR_ACC;
            end
            S_PR_ACC: begin
                if (k_reg == '0 || dot < min_reg) min_next = dot;
                if (k_reg == '0 || dot > max_reg) max_next = dot;
                if (k_shp == KIND_POLY && k_inc < n_shp) begin
                    k_next     = IDX_W'(k_inc);
                    state_next = S_PR_RD;
                end else if (k_shp == KIND_CIRCLE) begin
                    acc_next   = dot;
                    state_next = S_PR_EXT;
                end else begin
                    state_next = S_PR_END;
                end
            end
            S_PR_EXT: begin
                mul_a = $signed(MUL_W'(r_shp));
                mul_b = $signed(MUL_W'(len_reg));
                state_next = S_PR_EXT2;
            end
            S_PR_EXT2: begin
                min_next   = acc_reg - prod_x;
                max_next   = acc_reg + prod_x;
                state_next = S_PR_END;
            end

            // Compare intervals, then advance axis or pass
            S_PR_END: begin
                if (!shp_reg) begin
                    amin_next  = min_reg;
                    amax_next  = max_reg;
                    shp_next   = 1'b1;
                    k_next     = '0;
                    state_next = S_PR_RD;
                end else if (amax_reg < min_reg || max_reg < amin_reg) begin
                    coll_next  = 1'b0;
                    state_next = S_DONE;
                end else if (i_inc < n_own) begin
                    i_next     = IDX_W'(i_inc);
                    state_next = S_AX_RD_I;
                end else if (pass_after != PASS_NONE) begin
                    pass_next  = pass_after;
                    i_next     = '0;
                    state_next = S_AX_RD_I;
                end else begin
                    coll_next  = 1'b1;
                    state_next = S_DONE;
                end
            end

            // Hold the result until the output register takes it
            S_DONE: begin
                status.done = 1'b1;
                if (ack) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        na_reg <= na_next;     nb_reg <= nb_next;
        ka_reg <= ka_next;     kb_reg <= kb_next;
        ra_reg <= ra_next;     rb_reg <= rb_next;
        pass_reg <= pass_next; i_reg <= i_next; k_reg <= k_next;
        shp_reg <= shp_next;   coll_reg <= coll_next;
        px_reg <= px_next;     py_reg <= py_next;
        cx_reg <= cx_next;     cy_reg <= cy_next;
        vy_reg <= vy_next;
        ax_reg <= ax_next;     ay_reg <= ay_next;
        len_reg <= len_next;   acc_reg <= acc_next;
        min_reg <= min_next;   max_reg <= max_next;
        amin_reg <= amin_next; amax_reg <= amax_next;
    end

endmodule

/* hw/rtl/convex_shape_overlap_test_core.sv */
// Top level: vertex loading, shape bookkeeping, result register.
//
// Two-shape overlap test by separating axes in Q16.8. Vertices of the first
// shape (tuser sel 0) and then the second (sel 1) are taken one per cycle;
// tlast closes a shape, and closing the second shape starts the test, during
// which s_tready stays low. The test runs on one shared 26x26 multiplier under
// a sequencer: a point or circle pair gets a squared distance check; otherwise
// each axis takes a vertex fetch, plus the axis length (square root, one bit
// per cycle) when either shape is a circle, plus a projection of every vertex
// and a radius extent for a circle; the walk ends early when an axis separates.
// One result item (collide, overflow status) follows each closed second shape.
module convex_shape_overlap_test_core #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // vertex_x[23:0], vertex_y[47:24], radius[70:48]
    input  logic [2:0]  s_tuser,   // shape_sel[0], shape_kind[2:1]
    input  logic        s_tlast,   // last_vertex
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // collide[0], status[1]
);
    import csot_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int EFF_W = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SH    = FIELD_W - EFF_W;

    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    shape_info_t      info_a_reg, info_a_next, info_b_reg, info_b_next;
    logic             closed_a_reg, closed_a_next, closed_b_reg, closed_b_next;
    logic             ovf_reg, ovf_next, status_reg, status_next;
    logic             start_reg, start_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_coll_reg, m_coll_next, m_stat_reg, m_stat_next;

    logic              accept, sel, out_free, wr_en;
    logic [CNT_W-1:0]  cur_cnt;
    logic [FIELD_W-1:0] x_shl, y_shl;
    logic signed [FIELD_W-1:0] x_sx, y_sx;
    logic [VERT_W-1:0] wr_data;
    logic [IDX_W-1:0]  addr_a, addr_b;
    logic [VERT_W-1:0] rdata_a, rdata_b;
    seq_status_t       seq_st;

    assign sel      = s_tuser[0];
    assign s_tready = seq_st.idle && !start_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Sign-extend coordinates from the configured width
    always_comb begin
        x_shl   = s_tdata[FIELD_W-1:0] << SH;
        y_shl   = s_tdata[2*FIELD_W-1:FIELD_W] << SH;
        x_sx    = $signed(x_shl) >>> SH;
        y_sx    = $signed(y_shl) >>> SH;
        wr_data = {y_sx, x_sx};
    end

    // Track shapes, counts and overflow on accepted items
    always_comb begin
        cnt_a_next = cnt_a_reg;   cnt_b_next = cnt_b_reg;
        info_a_next = info_a_reg; info_b_next = info_b_reg;
        closed_a_next = closed_a_reg; closed_b_next = closed_b_reg;
        ovf_next = ovf_reg;
        status_next = status_reg;
        start_next = 1'b0;
        cur_cnt = sel ? (closed_b_reg ? '0 : cnt_b_reg) : (closed_a_reg ? '0 : cnt_a_reg);
        wr_en = accept && (cur_cnt < CNT_W'(MAX_VERTICES));
        if (accept) begin
            if (sel) begin
                closed_b_next = s_tlast;
                cnt_b_next = wr_en ? cur_cnt + 1'b1 : cur_cnt;
                if (cur_cnt == '0) info_b_next = {s_tuser[2:1], s_tdata[70:48]};
            end else begin
                closed_a_next = s_tlast;
                cnt_a_next = wr_en ? cur_cnt + 1'b1 : cur_cnt;
                if (cur_cnt == '0) info_a_next = {s_tuser[2:1], s_tdata[70:48]};
            end
            if (!wr_en) ovf_next = 1'b1;
            if (sel && s_tlast) begin
                status_next = ovf_next;
                ovf_next    = 1'b0;
                start_next  = 1'b1;
            end
        end
    end

    // Load the result register when the sequencer finishes
    always_comb begin
        m_valid_next = m_valid_reg;
        m_coll_next  = m_coll_reg;
        m_stat_next  = m_stat_reg;
        if (seq_st.done && out_free) begin
            m_valid_next = 1'b1;
            m_coll_next  = seq_st.collide;
            m_stat_next  = status_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;    cnt_b_reg <= '0;
            info_a_reg <= '0;   info_b_reg <= '0;
            closed_a_reg <= 1'b1; closed_b_reg <= 1'b1;
            ovf_reg <= 1'b0;
            start_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_a_reg <= cnt_a_next;   cnt_b_reg <= cnt_b_next;
            info_a_reg <= info_a_next; info_b_reg <= info_b_next;
            closed_a_reg <= closed_a_next; closed_b_reg <= closed_b_next;
            ovf_reg <= ovf_next;
            start_reg <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        m_coll_reg <= m_coll_next;
        m_stat_reg <= m_stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_stat_reg, m_coll_reg};

    csot_vmem #(.DEPTH(MAX_VERTICES)) u_vmem_a (
        .aclk    (aclk),
        .wr_en   (wr_en && !sel),
        .wr_addr (cur_cnt[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (addr_a),
        .rd_data (rdata_a)
    );

    csot_vmem #(.DEPTH(MAX_VERTICES)) u_vmem_b (
        .aclk    (aclk),
        .wr_en   (wr_en && sel),
        .wr_addr (cur_cnt[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (addr_b),
        .rd_data (rdata_b)
    );

    csot_seq #(.MAX_VERTICES(MAX_VERTICES)) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .n_a     (cnt_a_reg),
        .n_b     (cnt_b_reg),
        .info_a  (info_a_reg),
        .info_b  (info_b_reg),
        .addr_a  (addr_a),
        .addr_b  (addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .ack     (out_free),
        .status  (seq_st)
    );

`ifndef NO_ASSERTIONS
    a_cnt_a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_a_reg <= CNT_W'(MAX_VERTICES)) else $error("first shape count overrun");
    a_cnt_b_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_b_reg <= CNT_W'(MAX_VERTICES)) else $error("second shape count overrun");
    a_start_after_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && sel && s_tlast) |=> (start_reg && !s_tready))
        else $error("test did not start after second shape closed");
    a_ovf_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !ovf_reg) else $error("overflow not cleared at test start");
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_st.done && out_free) |=> m_tvalid) else $error("result item not loaded");
`endif

endmodule
